// ===== rtl/atcls_pkg.sv =====
`timescale 1ns / 1ps

package atcls_pkg;

   // Character codes that the line parser recognises.
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [6:0] CHAR_A      = 7'h41;
   localparam logic [6:0] CHAR_T      = 7'h54;
   localparam logic [6:0] CHAR_SEMI   = 7'h3B;
   localparam logic [6:0] CHAR_NUL    = 7'h00;
   localparam int         CHAR_WIDTH  = 7;

   // Result kinds.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ0,
      ST_CHECK_A,
      ST_CHECK_T,
      ST_SCAN,
      ST_END
   } atcls_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;
      logic load;
      logic advance;
      logic clear;
      logic scan;
      logic flush;
      logic emit_end;
   } atcls_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic eol;
      logic fill_short;
      logic char_is_a;
      logic char_is_t;
      logic body_end;
   } atcls_status_type;

endpackage

// ===== rtl/atcls_ram.sv =====
`timescale 1ns / 1ps

module atcls_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port and a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/atcls_dp.sv =====
`timescale 1ns / 1ps

module atcls_dp #(
   parameter int DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  atcls_pkg::atcls_cmd_type      cmd,
   output atcls_pkg::atcls_status_type   status,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_strobe,
   output logic                          rsp_kind,
   output logic [6:0]                    rsp_ch,
   output logic                          rsp_seg_first,
   output logic                          rsp_seg_last,
   output logic                          rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] wr_pos_ff, wr_pos_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [6:0]    pend_ch_ff, pend_ch_in;
   logic          pend_first_ff, pend_first_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [6:0]    rsp_ch_ff, rsp_ch_in;
   logic          rsp_seg_first_ff, rsp_seg_first_in;
   logic          rsp_seg_last_ff, rsp_seg_last_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    folded;
   logic [6:0]    wr_char;
   logic [6:0]    rd_data;
   logic [CW:0]   wr_ext;
   logic [CW:0]   fill_ext;
   logic [CW:0]   start_full;
   logic [AW-1:0] start_pos;

   // Upper-case fold of a..z only, then drop bit 7.
   always_comb begin
      if (req_in_byte >= atcls_pkg::LOWER_A && req_in_byte <= atcls_pkg::LOWER_Z) begin
         folded = req_in_byte - atcls_pkg::CASE_OFFSET;
      end else begin
         folded = req_in_byte;
      end
      wr_char = folded[6:0];
   end

   // The oldest stored character sits fill places behind the write position.
   always_comb begin
      wr_ext   = (CW + 1)'(wr_pos_ff);
      fill_ext = (CW + 1)'(fill_ff);
      if (wr_ext >= fill_ext) begin
         start_full = wr_ext - fill_ext;
      end else begin
         start_full = wr_ext + (CW + 1)'(DEPTH) - fill_ext;
      end
      start_pos = start_full[AW-1:0];
   end

   atcls_ram #(
      .WIDTH (atcls_pkg::CHAR_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wr_pos_ff),
      .wr_data (wr_char),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Status towards the controller.
   always_comb begin
      status.eol        = (req_in_byte == atcls_pkg::BYTE_CR) ||
                          (req_in_byte == atcls_pkg::BYTE_LF);
      status.fill_short = fill_ff < CW'(3);
      status.char_is_a  = rd_data == atcls_pkg::CHAR_A;
      status.char_is_t  = rd_data == atcls_pkg::CHAR_T;
      status.body_end   = (remain_ff == '0) || (rd_data == atcls_pkg::CHAR_NUL);
   end

   // Ring pointers and the read walk.
   always_comb begin
      wr_pos_in = wr_pos_ff;
      fill_in   = fill_ff;
      rd_ptr_in = rd_ptr_ff;
      remain_in = remain_ff;
      if (cmd.write) begin
         wr_pos_in = (wr_pos_ff == AW'(DEPTH - 1)) ? '0 : wr_pos_ff + 1'b1;
         if (fill_ff != CW'(DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.load) begin
         rd_ptr_in = start_pos;
         remain_in = fill_ff;
      end else if (cmd.advance) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         remain_in = remain_ff - 1'b1;
      end
      if (cmd.clear) begin
         wr_pos_in = '0;
         fill_in   = '0;
      end
   end

   // Segment splitting: one character is held back until the next one shows
   // whether it closes its segment.
   always_comb begin
      pend_valid_in    = pend_valid_ff;
      pend_ch_in       = pend_ch_ff;
      pend_first_in    = pend_first_ff;
      rsp_strobe_in    = 1'b0;
      rsp_kind_in      = atcls_pkg::KIND_CHAR;
      rsp_ch_in        = pend_ch_ff;
      rsp_seg_first_in = pend_first_ff;
      rsp_seg_last_in  = 1'b0;
      rsp_last_in      = 1'b0;
      if (cmd.load) begin
         pend_valid_in = 1'b0;
      end
      if (cmd.scan) begin
         rsp_strobe_in = pend_valid_ff;
         if (rd_data == atcls_pkg::CHAR_SEMI) begin
            rsp_seg_last_in = 1'b1;
            pend_valid_in   = 1'b0;
         end else begin
            pend_ch_in    = rd_data;
            pend_first_in = !pend_valid_ff;
            pend_valid_in = 1'b1;
         end
      end
      if (cmd.flush) begin
         rsp_strobe_in   = pend_valid_ff;
         rsp_seg_last_in = 1'b1;
         pend_valid_in   = 1'b0;
      end
      if (cmd.emit_end) begin
         rsp_strobe_in    = 1'b1;
         rsp_kind_in      = atcls_pkg::KIND_END;
         rsp_ch_in        = atcls_pkg::CHAR_NUL;
         rsp_seg_first_in = 1'b0;
         rsp_seg_last_in  = 1'b0;
         rsp_last_in      = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff     <= '0;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         wr_pos_ff     <= wr_pos_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff        <= rd_ptr_in;
      remain_ff        <= remain_in;
      pend_ch_ff       <= pend_ch_in;
      pend_first_ff    <= pend_first_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_ch_ff        <= rsp_ch_in;
      rsp_seg_first_ff <= rsp_seg_first_in;
      rsp_seg_last_ff  <= rsp_seg_last_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_ch        = rsp_ch_ff;
   assign rsp_seg_first = rsp_seg_first_ff;
   assign rsp_seg_last  = rsp_seg_last_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== rtl/atcls_ctrl.sv =====
`timescale 1ns / 1ps

module atcls_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  atcls_pkg::atcls_status_type  status,
   output atcls_pkg::atcls_cmd_type     cmd
);

   atcls_pkg::atcls_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atcls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         atcls_pkg::ST_IDLE: begin
            busy      = 1'b0;
            cmd.write = start;
            if (start && status.eol) begin
               state_in = atcls_pkg::ST_LOAD;
            end
         end
         atcls_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            if (status.fill_short) begin
               cmd.clear = 1'b1;
               state_in  = atcls_pkg::ST_IDLE;
            end else begin
               state_in = atcls_pkg::ST_READ0;
            end
         end
         atcls_pkg::ST_READ0: begin
            cmd.advance = 1'b1;
            state_in    = atcls_pkg::ST_CHECK_A;
         end
         atcls_pkg::ST_CHECK_A: begin
            if (status.char_is_a) begin
               cmd.advance = 1'b1;
               state_in    = atcls_pkg::ST_CHECK_T;
            end else begin
               cmd.clear = 1'b1;
               state_in  = atcls_pkg::ST_IDLE;
            end
         end
         atcls_pkg::ST_CHECK_T: begin
            if (status.char_is_t) begin
               cmd.advance = 1'b1;
               state_in    = atcls_pkg::ST_SCAN;
            end else begin
               cmd.clear = 1'b1;
               state_in  = atcls_pkg::ST_IDLE;
            end
         end
         atcls_pkg::ST_SCAN: begin
            if (status.body_end) begin
               cmd.flush = 1'b1;
               state_in  = atcls_pkg::ST_END;
            end else begin
               cmd.scan    = 1'b1;
               cmd.advance = 1'b1;
            end
         end
         atcls_pkg::ST_END: begin
            cmd.emit_end = 1'b1;
            cmd.clear    = 1'b1;
            state_in     = atcls_pkg::ST_IDLE;
         end
         default: begin
            state_in = atcls_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/at_command_line_splitter_top.sv =====
`timescale 1ns / 1ps

// AT command line splitter.
// Request channel: a received byte on req_in_byte is taken at a rising edge
// where start is high and busy is low. Each byte is folded to upper case,
// trimmed to 7 bits and stored in a ring of DEPTH characters.
// A byte that does not end a line leaves busy low.
// A CR or LF byte ends the line and raises busy while the ring is walked one
// character a cycle through the registered read port of the ring memory.
// Busy then stays high until the walk reaches the end of the stored line or a
// NUL, and drops early when the line is shorter than three characters or does
// not open with AT.
// Result channel: rsp_strobe marks each result for exactly one cycle. Segment
// characters come with rsp_seg_first / rsp_seg_last, and a final result with
// rsp_kind and rsp_last set closes an accepted line. The end result sits on
// the ports in the first cycle with busy low again.
// The receiver cannot stall; results are simply presented once.
// Reset empties the ring (no clearing pass), returns the controller to idle
// and removes any pending result.
module at_command_line_splitter_top #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_in_byte,
   output logic       rsp_strobe,
   output logic       rsp_kind,
   output logic [6:0] rsp_ch,
   output logic       rsp_seg_first,
   output logic       rsp_seg_last,
   output logic       rsp_last
);

   atcls_pkg::atcls_cmd_type    cmd;
   atcls_pkg::atcls_status_type status;

   atcls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   atcls_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_in_byte   (req_in_byte),
      .rsp_strobe    (rsp_strobe),
      .rsp_kind      (rsp_kind),
      .rsp_ch        (rsp_ch),
      .rsp_seg_first (rsp_seg_first),
      .rsp_seg_last  (rsp_seg_last),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTH
   // A request just taken never produces a result in the following cycle.
   a_no_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe)
      else $error("result strobe directly after an accepted request");

   // The end result is shown only once the controller is idle again.
   a_end_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == atcls_pkg::KIND_END |-> !busy)
      else $error("end result while the controller is still busy");

   // The end result carries no character and is the final one.
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |->
         rsp_kind == atcls_pkg::KIND_END && rsp_ch == atcls_pkg::CHAR_NUL &&
         !rsp_seg_first && !rsp_seg_last)
      else $error("malformed end result");

   // Segment characters are never separators or terminators.
   a_char_content: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == atcls_pkg::KIND_CHAR |->
         rsp_ch != atcls_pkg::CHAR_SEMI && rsp_ch != atcls_pkg::CHAR_NUL)
      else $error("separator or NUL emitted as a segment character");
`endif

endmodule
